// ===== rtl/lbpe_pkg.sv =====
// Shared types, constants and pattern table for the LED blink pattern engine.
`default_nettype none
package lbpe_pkg;

  localparam int unsigned NumPatterns = 14;
  localparam int unsigned NumFinite   = 8;
  localparam int unsigned NumLeds     = 4;
  localparam int unsigned CntW        = 8;

  // request codes
  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqSet   = 2'd1;
  localparam logic [1:0] ReqClear = 2'd2;

  // register indexes
  localparam logic RegPeriod = 1'b0;
  localparam logic RegDir    = 1'b1;

  localparam logic [CntW-1:0] PeriodReset = 8'd10;

  typedef logic [NumPatterns-1:0] flags_t;
  typedef logic [NumLeds-1:0]     leds_t;
  typedef logic [CntW-1:0]        cnt_t;

  typedef struct packed {
    flags_t     flags;
    cnt_t       finite_cnt;
    logic [1:0] repeat_cnt;
    cnt_t       three_cnt;
    cnt_t       pair_cnt;
    cnt_t       single_cnt;
    leds_t      leds;
  } state_t;

  typedef struct packed {
    cnt_t period;
    logic dir;
  } cfg_t;

  // LED group served by each pattern; bit i drives LED i+1
  function automatic leds_t group_mask(input logic [3:0] idx, input logic dir);
    leds_t m;
    case (idx)
      4'd0:    m = 4'hF;
      4'd1:    m = 4'h1;
      4'd2:    m = 4'h2;
      4'd3:    m = 4'h8;
      4'd4:    m = 4'h3;
      4'd5:    m = 4'hA;
      4'd6:    m = 4'h9;
      4'd7:    m = 4'hD;
      4'd8:    m = dir ? 4'hE : 4'h7;
      4'd9:    m = 4'hC;
      4'd10:   m = dir ? 4'h8 : 4'h1;
      4'd11:   m = 4'h8;
      4'd12:   m = 4'h4;
      4'd13:   m = 4'h2;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lbpe_if.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface lbpe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] pattern_index;

  modport source (output valid, output req_type, output pattern_index, input ready);
  modport sink (input valid, input req_type, input pattern_index, output ready);
endinterface

interface lbpe_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  led_state;
  logic [13:0] active_patterns;
  logic        pattern_done;

  modport source (output valid, output led_state, output active_patterns,
                  output pattern_done, input ready);
  modport sink (input valid, input led_state, input active_patterns,
                input pattern_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/led_blink_pattern_engine.sv =====
// LED blink pattern engine: input register, state update, result register.
// A request waits in the input register until the result register is free.
// Throughput: one request per cycle unless a result is held; the pattern state
// register closes an update loop between input register and result register.
// Reset (rst_ni low, asynchronous): all flags, counters and LEDs cleared,
// blink period 10, sweep direction 0, both pipeline stages empty.
`default_nettype none
module led_blink_pattern_engine
  import lbpe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lbpe_in_if.sink          in_if,
  lbpe_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  state_t     state_q, state_d;
  logic       done_d;
  logic       s1_vld_q;
  logic [1:0] s1_req_q;
  logic [3:0] s1_idx_q;
  logic       out_vld_q;
  leds_t      out_leds_q;
  flags_t     out_flags_q;
  logic       out_done_q;
  logic       out_free;
  logic       s1_adv;

  lbpe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbpe_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg),
    .req_i   (s1_req_q),
    .idx_i   (s1_idx_q),
    .state_o (state_d),
    .done_o  (done_d)
  );

  assign out_free    = !out_vld_q || out_if.ready;
  assign s1_adv      = s1_vld_q && out_free;
  assign in_if.ready = !s1_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_if.ready) s1_vld_q <= in_if.valid;
      if (out_free)    out_vld_q <= s1_vld_q;
      if (s1_adv)      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_req_q <= in_if.req_type;
      s1_idx_q <= in_if.pattern_index;
    end
    if (s1_adv) begin
      out_leds_q  <= state_d.leds;
      out_flags_q <= state_d.flags;
      out_done_q  <= done_d;
    end
  end

  assign out_if.valid           = out_vld_q;
  assign out_if.led_state       = out_leds_q;
  assign out_if.active_patterns = out_flags_q;
  assign out_if.pattern_done    = out_done_q;

endmodule
`default_nettype wire

// ===== rtl/lbpe_regs.sv =====
// APB-style configuration registers: blink period and sweep direction.
`default_nettype none
module lbpe_regs
  import lbpe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cnt_t period_q;
  logic dir_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // byte-lane bits of paddr are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      dir_q    <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == RegPeriod) period_q <= pwdata[CntW-1:0];
      if (paddr[2] == RegDir)    dir_q    <= pwdata[0];
    end
  end

  always_comb begin
    if (paddr[2] == RegDir) prdata = {31'd0, dir_q};
    else                    prdata = {{(32-CntW){1'b0}}, period_q};
  end

  assign cfg_o.period = period_q;
  assign cfg_o.dir    = dir_q;

endmodule
`default_nettype wire

// ===== rtl/lbpe_step.sv =====
// Next-state logic for one request: flag update or served tick.
`default_nettype none
module lbpe_step
  import lbpe_pkg::*;
(
  input  wire state_t      state_i,
  input  wire cfg_t        cfg_i,
  input  wire logic [1:0]  req_i,
  input  wire logic [3:0]  idx_i,
  output state_t           state_o,
  output logic             done_o
);

  logic [3:0] sel;
  logic       any;
  leds_t      mask;
  cnt_t       cnt, cnt_inc;
  logic       wrap, lit;
  logic [1:0] rep_inc;
  logic       finite;
  logic       finish;
  flags_t     idx_bit;
  flags_t     sel_bit;

  // highest-priority set flag (flag 0 wins)
  always_comb begin
    sel = 4'd0;
    any = 1'b0;
    for (int i = NumPatterns - 1; i >= 0; i--) begin
      if (state_i.flags[i]) begin
        sel = 4'(i);
        any = 1'b1;
      end
    end
  end

  assign mask   = group_mask(sel, cfg_i.dir);
  assign finite = (sel < 4'(NumFinite));

  always_comb begin
    if (finite)         cnt = state_i.finite_cnt;
    else if (sel == 4'd8) cnt = state_i.three_cnt;
    else if (sel == 4'd9) cnt = state_i.pair_cnt;
    else                cnt = state_i.single_cnt;
  end

  assign cnt_inc = cnt + cnt_t'(1);
  assign wrap    = (cnt_inc > cfg_i.period);
  assign lit     = wrap || (cnt_inc > (cfg_i.period >> 1));
  assign rep_inc = state_i.repeat_cnt + 2'd1;
  assign finish  = wrap && finite && (rep_inc >= ((sel == 4'd0) ? 2'd2 : 2'd3));
  assign idx_bit = flags_t'(1) << idx_i;
  assign sel_bit = flags_t'(1) << sel;

  always_comb begin
    cnt_t nc;
    nc      = wrap ? '0 : cnt_inc;
    state_o = state_i;
    done_o  = 1'b0;
    case (req_i)
      ReqTick: begin
        if (any) begin
          if (finite)           state_o.finite_cnt = nc;
          else if (sel == 4'd8) state_o.three_cnt  = nc;
          else if (sel == 4'd9) state_o.pair_cnt   = nc;
          else                  state_o.single_cnt = nc;
          state_o.leds = lit ? (state_i.leds | mask) : (state_i.leds & ~mask);
          if (wrap && finite) begin
            state_o.repeat_cnt = rep_inc;
            if (finish) begin
              state_o.repeat_cnt = 2'd0;
              state_o.flags      = state_i.flags & ~sel_bit;
              state_o.leds       = state_i.leds & ~mask;
              done_o             = 1'b1;
            end
          end
        end
      end
      ReqSet: begin
        if (idx_i < 4'(NumPatterns)) state_o.flags = state_i.flags | idx_bit;
      end
      ReqClear: begin
        if (idx_i < 4'(NumPatterns)) state_o.flags = state_i.flags & ~idx_bit;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
